/* rtl/mws_pkg.sv */
// Package for mode_with_shortest_span: sizes, the element record that passes
// from the front end through the queue to the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mws_pkg;

	localparam int VALUE_BITS = 8;
	localparam int INDEX_BITS = 16;
	localparam int COUNT_BITS = INDEX_BITS + 1;
	localparam int NVALUES    = 1 << VALUE_BITS;
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [INDEX_BITS-1:0] index;
		logic                  drop;
		logic                  last;
	} item_t;

endpackage
`default_nettype wire

/* rtl/mws_front.sv */
// Front end: accepts elements, assigns each its index within the array and
// marks elements beyond the index range for dropping.
// Depends on mws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mws_front
	import mws_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [7:0]            elem_value,
	input  wire logic                  is_last,
	input  wire logic                  elem_valid,
	output logic                       elem_stall,
	input  wire logic                  q_full,
	output logic                       push,
	output item_t                      push_item
);

	logic [COUNT_BITS-1:0] pos_q;

	assign elem_stall = q_full;
	assign push       = elem_valid && !q_full;

	always_comb begin
		push_item.value = elem_value[VALUE_BITS-1:0];
		push_item.index = pos_q[INDEX_BITS-1:0];
		push_item.drop  = pos_q[INDEX_BITS];
		push_item.last  = is_last;
	end

	// advance the index, saturate at the limit, restart after the last element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (is_last) begin
				pos_q <= '0;
			end else if (!pos_q[INDEX_BITS]) begin
				pos_q <= pos_q + COUNT_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/mws_queue.sv */
// Short first-in first-out queue of element records between front and back.
// Depends on mws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mws_queue
	import mws_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  item_t      push_item,
	output logic       full,
	input  wire logic  pop,
	output logic       not_empty,
	output item_t      head
);

	item_t                 slot_q [QDEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q;
	logic [QPTR_BITS-1:0]  rd_ptr_q;
	logic [QPTR_BITS:0]    count_q;

	assign full      = (count_q == (QPTR_BITS+1)'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_BITS+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_BITS+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/mws_back.sv */
// Back end: per-value count and first-index tables with forwarding, the
// running best record, and the result register.
// Depends on mws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mws_back
	import mws_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_not_empty,
	input  item_t             q_head,
	output logic              pop,
	output logic              res_valid,
	input  wire logic         res_stall,
	output logic [7:0]        mode_value,
	output logic [15:0]       first_index,
	output logic [15:0]       last_index,
	output logic [16:0]       occurrences,
	output logic              overflow
);

	logic [COUNT_BITS-1:0] cnt_mem [NVALUES];
	logic [INDEX_BITS-1:0] fst_mem [NVALUES];
	logic [NVALUES-1:0]    seen_q;

	logic                  valid_s1;
	item_t                 item_s1;
	logic [COUNT_BITS-1:0] cnt_rd_s1;
	logic [INDEX_BITS-1:0] fst_rd_s1;

	logic                  wr_valid_q;
	logic [VALUE_BITS-1:0] wr_addr_q;
	logic [COUNT_BITS-1:0] wr_cnt_q;
	logic [INDEX_BITS-1:0] wr_fst_q;

	logic [VALUE_BITS-1:0] best_value_q;
	logic [COUNT_BITS-1:0] best_count_q;
	logic [INDEX_BITS-1:0] best_first_q;
	logic [INDEX_BITS-1:0] best_last_q;
	logic [INDEX_BITS-1:0] best_span_q;
	logic                  ovf_q;

	logic                  res_valid_q;
	logic [VALUE_BITS-1:0] res_value_q;
	logic [INDEX_BITS-1:0] res_first_q;
	logic [INDEX_BITS-1:0] res_last_q;
	logic [COUNT_BITS-1:0] res_count_q;
	logic                  res_ovf_q;

	logic                  out_free;
	logic                  adv;
	logic                  commit;
	logic                  counted;
	logic [COUNT_BITS-1:0] prev_cnt;
	logic [INDEX_BITS-1:0] prev_fst;
	logic [COUNT_BITS-1:0] cnt;
	logic [INDEX_BITS-1:0] fst;
	logic [INDEX_BITS-1:0] span;
	logic                  better;
	logic [VALUE_BITS-1:0] nb_value;
	logic [COUNT_BITS-1:0] nb_count;
	logic [INDEX_BITS-1:0] nb_first;
	logic [INDEX_BITS-1:0] nb_last;
	logic [INDEX_BITS-1:0] nb_span;
	logic                  nb_ovf;

	assign out_free = !res_valid_q || !res_stall;
	assign commit   = valid_s1 && (!item_s1.last || out_free);
	assign adv      = !valid_s1 || commit;
	assign pop      = adv && q_not_empty;
	assign counted  = commit && !item_s1.drop;

	// forward the newest write over the registered read
	always_comb begin
		if (wr_valid_q && (wr_addr_q == item_s1.value)) begin
			prev_cnt = wr_cnt_q;
			prev_fst = wr_fst_q;
		end else begin
			prev_cnt = cnt_rd_s1;
			prev_fst = fst_rd_s1;
		end
		if (seen_q[item_s1.value]) begin
			cnt = prev_cnt + COUNT_BITS'(1);
			fst = prev_fst;
		end else begin
			cnt = COUNT_BITS'(1);
			fst = item_s1.index;
		end
		span = item_s1.index - fst;
		priority if (cnt != best_count_q) begin
			better = cnt > best_count_q;
		end else if (span != best_span_q) begin
			better = span < best_span_q;
		end else begin
			better = fst < best_first_q;
		end
		if (!item_s1.drop && better) begin
			nb_value = item_s1.value;
			nb_count = cnt;
			nb_first = fst;
			nb_last  = item_s1.index;
			nb_span  = span;
		end else begin
			nb_value = best_value_q;
			nb_count = best_count_q;
			nb_first = best_first_q;
			nb_last  = best_last_q;
			nb_span  = best_span_q;
		end
		nb_ovf = ovf_q || item_s1.drop;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cnt_rd_s1 <= cnt_mem[q_head.value];
			fst_rd_s1 <= fst_mem[q_head.value];
		end
	end

	always_ff @(posedge clk) begin
		if (counted) begin
			cnt_mem[item_s1.value] <= cnt;
			fst_mem[item_s1.value] <= fst;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= q_head;
		end
		if (counted) begin
			wr_addr_q <= item_s1.value;
			wr_cnt_q  <= cnt;
			wr_fst_q  <= fst;
		end
		if (commit && item_s1.last) begin
			res_value_q <= nb_value;
			res_first_q <= nb_first;
			res_last_q  <= nb_last;
			res_count_q <= nb_count;
			res_ovf_q   <= nb_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			wr_valid_q   <= 1'b0;
			seen_q       <= '0;
			best_value_q <= '0;
			best_count_q <= '0;
			best_first_q <= '0;
			best_last_q  <= '0;
			best_span_q  <= '0;
			ovf_q        <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (adv) begin
				valid_s1 <= q_not_empty;
			end
			if (counted) begin
				wr_valid_q <= 1'b1;
			end
			if (commit && item_s1.last) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (commit) begin
				if (item_s1.last) begin
					seen_q       <= '0;
					best_value_q <= '0;
					best_count_q <= '0;
					best_first_q <= '0;
					best_last_q  <= '0;
					best_span_q  <= '0;
					ovf_q        <= 1'b0;
				end else begin
					if (!item_s1.drop) begin
						seen_q[item_s1.value] <= 1'b1;
					end
					best_value_q <= nb_value;
					best_count_q <= nb_count;
					best_first_q <= nb_first;
					best_last_q  <= nb_last;
					best_span_q  <= nb_span;
					ovf_q        <= nb_ovf;
				end
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign mode_value  = 8'(res_value_q);
	assign first_index = 16'(res_first_q);
	assign last_index  = 16'(res_last_q);
	assign occurrences = 17'(res_count_q);
	assign overflow    = res_ovf_q;

endmodule
`default_nettype wire

/* rtl/mode_with_shortest_span.sv */
// Top level of mode_with_shortest_span: front end, queue and back end.
// Depends on mws_pkg, mws_front, mws_queue, mws_back.
//
// Streams one array element per transfer on the elem channel; the element
// with is_last set closes the array and yields one transfer on the res
// channel: the most frequent value (ties go to the shortest first-to-last
// span, then to the earliest first occurrence), its first and last index,
// its count, and an overflow flag when the array held more than 65536
// elements (the result then covers the first 65536). The block sustains one
// element per clock while the res channel does not stall: the per-value count
// and first-index tables take one read-modify-write per element, with the
// newest write forwarded over the registered read. A four-entry queue
// separates acceptance from table processing; a last element passes through
// the queue slot and the stage-1 register before its result is registered.
// No clearing pass is needed after reset or between arrays.
`timescale 1ns / 1ps
`default_nettype none
module mode_with_shortest_span
	import mws_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [7:0]   elem_value,
	input  wire logic         is_last,
	input  wire logic         elem_valid,
	output logic              elem_stall,
	output logic              res_valid,
	input  wire logic         res_stall,
	output logic [7:0]        mode_value,
	output logic [15:0]       first_index,
	output logic [15:0]       last_index,
	output logic [16:0]       occurrences,
	output logic              overflow
);

	logic  q_full;
	logic  push;
	item_t push_item;
	logic  pop;
	logic  q_not_empty;
	item_t q_head;

	mws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem_value (elem_value),
		.is_last    (is_last),
		.elem_valid (elem_valid),
		.elem_stall (elem_stall),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	mws_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	mws_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.mode_value  (mode_value),
		.first_index (first_index),
		.last_index  (last_index),
		.occurrences (occurrences),
		.overflow    (overflow)
	);

endmodule
`default_nettype wire
